/* rtl/swsd_pkg.sv */
// swsd_pkg: shared types, constants and helpers for the scale weight settle detector
// no dependencies; imported by every module of the block
package swsd_pkg;

    localparam int DET_W   = 23;
    localparam int CHG_W   = 10;
    localparam int REQ_W   = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;
    localparam int SCALE_W = 10;

    localparam logic [SCALE_W-1:0] CHANGE_SCALE = 10'd1000;

    localparam logic [DET_W-1:0] DETECT_RST   = 23'd50;
    localparam logic [CHG_W-1:0] CHANGE_RST   = 10'd20;
    localparam logic [REQ_W-1:0] REQUIRED_RST = 8'd5;
    localparam logic [REQ_W-1:0] STEADY_MAX   = 8'hFF;
    localparam logic [REQ_W-1:0] STEADY_ONE   = 8'd1;

    localparam int SETTLE_RST  = 5000;
    localparam int REMOVAL_RST = 1000;

    typedef enum logic [IDX_W-1:0] {
        REG_DETECT   = 3'd0,
        REG_CHANGE   = 3'd1,
        REG_READINGS = 3'd2,
        REG_SETTLE   = 3'd3,
        REG_REMOVAL  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_EMPTY       = 4'b0001,
        ST_STABILIZING = 4'b0010,
        ST_STABLE      = 4'b0100,
        ST_REMOVING    = 4'b1000
    } t_phase;

    localparam logic [1:0] PH_EMPTY       = 2'd0;
    localparam logic [1:0] PH_STABILIZING = 2'd1;
    localparam logic [1:0] PH_STABLE      = 2'd2;
    localparam logic [1:0] PH_REMOVING    = 2'd3;

    typedef struct packed {
        logic [DET_W-1:0] detect;
        logic [CHG_W-1:0] change;
        logic [REQ_W-1:0] required;
    } t_cfg;

    function automatic logic [1:0] phase_code(input t_phase p);
        logic [1:0] c;
        case (p)
            ST_EMPTY:       c = PH_EMPTY;
            ST_STABILIZING: c = PH_STABILIZING;
            ST_STABLE:      c = PH_STABLE;
            ST_REMOVING:    c = PH_REMOVING;
            default:        c = PH_EMPTY;
        endcase
        return c;
    endfunction

endpackage

/* rtl/scale_weight_settle_detector_unit.sv */
// scale_weight_settle_detector_unit: top level with input register, core and result register
// depends on swsd_pkg, swsd_cfg, swsd_core
//
// usage:
//   input channel (i_valid / o_stall) carries one beat per sample or tick:
//   i_operation 0 = weight sample in i_weight, 1 = one time tick; i_clear_event
//   clears the sticky event flag before the beat is applied.
//   output channel (o_valid / i_stall) returns exactly one beat per input beat:
//   o_phase, o_settled_weight and o_event_pending as they stand after that beat.
//   a beat is taken at a rising edge where valid is high and stall is low.
//   a beat in the input register is stepped into the result register once that is free.
//   throughput: one beat per cycle while the receiver does not stall; the state update
//   is one pass through the change compare (a 10 x 24 bit and a 10 x 25 bit multiply
//   and a compare) between the input register and the result register.
//   when the receiver stalls, the result register holds and the input register
//   still takes one more beat; o_stall rises only when both are full.
//   reset (synchronous, active low) empties both registers, puts the detector in
//   the empty phase with zero weights and counts, and loads register defaults.
//   apb registers at 4*i: detect threshold, change threshold, readings required,
//   settle timeout, removal confirm; write them only while the block is idle.
module scale_weight_settle_detector_unit #(
    parameter int WEIGHT_WIDTH = 24,
    parameter int TICK_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_operation,
    input  logic signed [WEIGHT_WIDTH-1:0] i_weight,
    input  logic                           i_clear_event,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_phase,
    output logic signed [WEIGHT_WIDTH-1:0] o_settled_weight,
    output logic                           o_event_pending,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [swsd_pkg::DATA_W-1:0]    pwdata,
    output logic [swsd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import swsd_pkg::*;

    t_cfg                          cfg;
    logic [TICK_WIDTH-1:0]         settle_timeout;
    logic [TICK_WIDTH-1:0]         removal_confirm;

    logic                          r_in_valid;
    logic                          r_in_op;
    logic signed [WEIGHT_WIDTH-1:0] r_in_weight;
    logic                          r_in_clear;

    logic                          r_out_valid;
    logic [1:0]                    r_out_phase;
    logic signed [WEIGHT_WIDTH-1:0] r_out_weight;
    logic                          r_out_event;

    logic                          out_free;
    logic                          in_free;
    logic                          step;
    logic [1:0]                    core_phase;
    logic signed [WEIGHT_WIDTH-1:0] core_weight;
    logic                          core_event;

    assign out_free = !r_out_valid || !i_stall;
    assign in_free  = !r_in_valid || out_free;
    assign step     = r_in_valid && out_free;
    assign o_stall  = !in_free;

    swsd_cfg #(
        .TICK_WIDTH(TICK_WIDTH)
    ) u_cfg (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .o_cfg             (cfg),
        .o_settle_timeout  (settle_timeout),
        .o_removal_confirm (removal_confirm)
    );

    swsd_core #(
        .WEIGHT_WIDTH(WEIGHT_WIDTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_operation       (r_in_op),
        .i_weight          (r_in_weight),
        .i_clear_event     (r_in_clear),
        .i_cfg             (cfg),
        .i_settle_timeout  (settle_timeout),
        .i_removal_confirm (removal_confirm),
        .o_phase           (core_phase),
        .o_settled_weight  (core_weight),
        .o_event_pending   (core_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_op     <= i_operation;
            r_in_weight <= i_weight;
            r_in_clear  <= i_clear_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_phase  <= core_phase;
            r_out_weight <= core_weight;
            r_out_event  <= core_event;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_phase          = r_out_phase;
    assign o_settled_weight = r_out_weight;
    assign o_event_pending  = r_out_event;

endmodule

/* rtl/swsd_cfg.sv */
// swsd_cfg: apb register file for the settle detector thresholds and timeouts
// depends on swsd_pkg
module swsd_cfg #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swsd_pkg::ADDR_W-1:0]   paddr,
    input  logic [swsd_pkg::DATA_W-1:0]   pwdata,
    output logic [swsd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output swsd_pkg::t_cfg                o_cfg,
    output logic [TICK_WIDTH-1:0]         o_settle_timeout,
    output logic [TICK_WIDTH-1:0]         o_removal_confirm
);
    import swsd_pkg::*;

    logic [DET_W-1:0]      r_detect;
    logic [CHG_W-1:0]      r_change;
    logic [REQ_W-1:0]      r_required;
    logic [TICK_WIDTH-1:0] r_settle;
    logic [TICK_WIDTH-1:0] r_removal;
    logic                  wr_en;
    logic [IDX_W-1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect   <= DETECT_RST;
            r_change   <= CHANGE_RST;
            r_required <= REQUIRED_RST;
            r_settle   <= TICK_WIDTH'(SETTLE_RST);
            r_removal  <= TICK_WIDTH'(REMOVAL_RST);
        end else if (wr_en) begin
            case (idx)
                REG_DETECT:   r_detect   <= pwdata[DET_W-1:0];
                REG_CHANGE:   r_change   <= pwdata[CHG_W-1:0];
                REG_READINGS: r_required <= pwdata[REQ_W-1:0];
                REG_SETTLE:   r_settle   <= pwdata[TICK_WIDTH-1:0];
                REG_REMOVAL:  r_removal  <= pwdata[TICK_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DETECT:   prdata = DATA_W'(r_detect);
            REG_CHANGE:   prdata = DATA_W'(r_change);
            REG_READINGS: prdata = DATA_W'(r_required);
            REG_SETTLE:   prdata = DATA_W'(r_settle);
            REG_REMOVAL:  prdata = DATA_W'(r_removal);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.detect       = r_detect;
    assign o_cfg.change       = r_change;
    assign o_cfg.required     = r_required;
    assign o_settle_timeout   = r_settle;
    assign o_removal_confirm  = r_removal;

endmodule

/* rtl/swsd_cmp.sv */
// swsd_cmp: relative change compare, |w - ref| * 1000 against threshold * ref
// depends on swsd_pkg
module swsd_cmp #(
    parameter int WEIGHT_WIDTH = 24
) (
    input  logic signed [WEIGHT_WIDTH-1:0] i_weight,
    input  logic signed [WEIGHT_WIDTH-1:0] i_ref,
    input  logic [swsd_pkg::CHG_W-1:0]     i_change,
    output logic                           o_small,
    output logic                           o_big
);
    import swsd_pkg::*;

    localparam int DIFF_W = WEIGHT_WIDTH + 1;
    localparam int PROD_W = DIFF_W + SCALE_W;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [PROD_W-1:0]        lhs;
    logic [PROD_W-1:0]        rhs;
    logic                     ref_pos;

    assign diff    = DIFF_W'(i_weight) - DIFF_W'(i_ref);
    assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign lhs     = PROD_W'(mag) * PROD_W'(CHANGE_SCALE);
    assign rhs     = PROD_W'(i_change) * PROD_W'($unsigned(i_ref));
    assign ref_pos = !i_ref[WEIGHT_WIDTH-1] && (i_ref != '0);

    assign o_small = ref_pos && (lhs < rhs);
    assign o_big   = !ref_pos || (lhs > rhs);

endmodule

/* rtl/swsd_core.sv */
// swsd_core: settle detector state registers and single-step next-state logic
// depends on swsd_pkg and swsd_cmp
module swsd_core #(
    parameter int WEIGHT_WIDTH = 24,
    parameter int TICK_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_operation,
    input  logic signed [WEIGHT_WIDTH-1:0] i_weight,
    input  logic                           i_clear_event,
    input  swsd_pkg::t_cfg                 i_cfg,
    input  logic [TICK_WIDTH-1:0]          i_settle_timeout,
    input  logic [TICK_WIDTH-1:0]          i_removal_confirm,
    output logic [1:0]                     o_phase,
    output logic signed [WEIGHT_WIDTH-1:0] o_settled_weight,
    output logic                           o_event_pending
);
    import swsd_pkg::*;

    localparam int CNT_W = TICK_WIDTH + 1;
    localparam int CMP_W = ((WEIGHT_WIDTH > DET_W) ? WEIGHT_WIDTH : DET_W) + 1;
    localparam logic [CNT_W-1:0] TICKS_MAX = {CNT_W{1'b1}};

    t_phase                    r_phase;
    t_phase                    n_phase;
    logic signed [WEIGHT_WIDTH-1:0] r_last;
    logic signed [WEIGHT_WIDTH-1:0] n_last;
    logic signed [WEIGHT_WIDTH-1:0] r_stable;
    logic signed [WEIGHT_WIDTH-1:0] n_stable;
    logic [REQ_W-1:0]          r_steady;
    logic [REQ_W-1:0]          n_steady;
    logic [CNT_W-1:0]          r_ticks;
    logic [CNT_W-1:0]          n_ticks;
    logic                      r_event;
    logic                      n_event;

    logic [CNT_W-1:0]          ticks_a;
    logic [REQ_W-1:0]          steady_inc;
    logic signed [CMP_W-1:0]   w_ext;
    logic signed [CMP_W-1:0]   det_ext;
    logic                      w_above;
    logic                      w_below;
    logic signed [WEIGHT_WIDTH-1:0] cmp_ref;
    logic                      small_chg;
    logic                      big_chg;

    assign w_ext      = CMP_W'(i_weight);
    assign det_ext    = $signed(CMP_W'(i_cfg.detect));
    assign w_above    = w_ext > det_ext;
    assign w_below    = w_ext < det_ext;
    assign cmp_ref    = (r_phase == ST_STABLE) ? r_stable : r_last;
    assign steady_inc = (r_steady == STEADY_MAX) ? r_steady : r_steady + STEADY_ONE;

    swsd_cmp #(
        .WEIGHT_WIDTH(WEIGHT_WIDTH)
    ) u_cmp (
        .i_weight (i_weight),
        .i_ref    (cmp_ref),
        .i_change (i_cfg.change),
        .o_small  (small_chg),
        .o_big    (big_chg)
    );

    always_comb begin
        n_phase  = r_phase;
        n_last   = r_last;
        n_stable = r_stable;
        n_steady = r_steady;
        n_event  = r_event && !i_clear_event;
        ticks_a  = r_ticks;
        if (i_operation) begin
            if (r_ticks != TICKS_MAX) begin
                ticks_a = r_ticks + CNT_W'(1);
            end
        end else begin
            n_last = i_weight;
            case (r_phase)
                ST_EMPTY: begin
                    if (w_above) begin
                        n_phase  = ST_STABILIZING;
                        n_steady = STEADY_ONE;
                    end
                end
                ST_STABILIZING: begin
                    if (small_chg) begin
                        n_steady = steady_inc;
                        if (steady_inc >= i_cfg.required) begin
                            n_phase  = ST_STABLE;
                            n_stable = i_weight;
                            n_event  = 1'b1;
                        end
                    end else begin
                        n_steady = STEADY_ONE;
                    end
                end
                ST_STABLE: begin
                    if (w_below) begin
                        n_phase = ST_REMOVING;
                    end else if (big_chg) begin
                        n_phase  = ST_STABILIZING;
                        n_steady = STEADY_ONE;
                    end else begin
                        n_stable = i_weight;
                    end
                end
                ST_REMOVING: begin
                    if (w_above) begin
                        n_phase = ST_STABLE;
                    end
                end
                default: n_phase = ST_EMPTY;
            endcase
        end
        n_ticks = (n_phase != r_phase) ? '0 : ticks_a;
        // timeouts, checked after every beat
        if (n_phase == ST_STABILIZING && n_ticks > CNT_W'(i_settle_timeout)) begin
            n_phase = ST_EMPTY;
            n_ticks = '0;
        end else if (n_phase == ST_REMOVING && n_ticks > CNT_W'(i_removal_confirm)) begin
            n_phase  = ST_EMPTY;
            n_ticks  = '0;
            n_stable = '0;
            n_event  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ST_EMPTY;
            r_last   <= '0;
            r_stable <= '0;
            r_steady <= '0;
            r_ticks  <= '0;
            r_event  <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_stable <= n_stable;
            r_steady <= n_steady;
            r_ticks  <= n_ticks;
            r_event  <= n_event;
        end
    end

    assign o_phase          = phase_code(n_phase);
    assign o_settled_weight = n_stable;
    assign o_event_pending  = n_event;

endmodule

/* rtl/swsd_checker.sv */
// swsd_checker: port-level assertions for the settle detector, bound to the top level
// depends on swsd_pkg and scale_weight_settle_detector_unit
module swsd_checker #(
    parameter int WEIGHT_WIDTH = 24
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [1:0]                     o_phase,
    input logic signed [WEIGHT_WIDTH-1:0] o_settled_weight,
    input logic                           o_event_pending
);
    import swsd_pkg::*;

    logic [1:0] r_prev_phase;
    logic       out_beat;

    assign out_beat = o_valid && !i_stall;

    // phase of the last delivered beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_phase <= PH_EMPTY;
        end else if (out_beat) begin
            r_prev_phase <= o_phase;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_phase)
            && $stable(o_settled_weight) && $stable(o_event_pending)))
        else $error("stalled result beat changed");

    a_empty_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_prev_phase == PH_EMPTY)
            |-> (o_phase == PH_EMPTY || o_phase == PH_STABILIZING))
        else $error("empty phase left to other than stabilizing");

    a_removal_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && r_prev_phase == PH_REMOVING && o_phase == PH_EMPTY)
            |-> (o_event_pending && o_settled_weight == '0))
        else $error("confirmed removal without event or with nonzero weight");

endmodule

bind scale_weight_settle_detector_unit swsd_checker #(
    .WEIGHT_WIDTH(WEIGHT_WIDTH)
) u_swsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_phase          (o_phase),
    .o_settled_weight (o_settled_weight),
    .o_event_pending  (o_event_pending)
);
